>>> rtl/dtq_pkg.sv
// Types and constants shared by the deadline timer queue modules.
package dtq_pkg;

  localparam int unsigned DEADLINE_W  = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned POP_CNT_W   = $clog2(MAX_RESULTS);

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  localparam logic [DEADLINE_W-1:0] TIME_MAX = {DEADLINE_W{1'b1}};

  typedef struct packed {
    logic                  valid;
    logic [DEADLINE_W-1:0] deadline;
    logic [DATA_W-1:0]     data;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

endpackage

>>> rtl/dtq_cell.sv
// One cell of the sorted timer chain: holds one entry and shifts on insert or pop.
module dtq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dtq_pkg::cell_ctl_t ctl,
  input  dtq_pkg::entry_t   ins_entry,
  input  dtq_pkg::entry_t   prev_entry,
  input  logic              prev_goes,
  input  dtq_pkg::entry_t   next_entry,
  output dtq_pkg::entry_t   entry_q,
  output logic              goes_here
);
  import dtq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry_q   = entry_r;
  assign goes_here = !entry_r.valid || (entry_r.deadline > ins_entry.deadline);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = next_entry;
    end else if (ctl.ins) begin
      if (prev_goes) begin
        entry_nxt = prev_entry;
      end else if (goes_here) begin
        entry_nxt = ins_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.deadline <= entry_nxt.deadline;
    entry_r.data     <= entry_nxt.data;
  end

endmodule

>>> rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: a sorted chain of timer cells.
//
// Input channel (in_*): an add transfer (in_func = 0) stores in_entry_data with the
// deadline elapsed time plus in_delay_seconds, saturating at the maximum time.
// A tick transfer (in_func = 1) advances the elapsed time by one second,
// saturating, and then emits every stored entry that is due, earliest deadline
// first and equal deadlines in arrival order, at most sixteen per tick.
// Output channel (out_*): out_kind 0 is an expired entry, 1 a rejected add to a
// full table; out_last marks the final result of one input transfer.
// Operation: on an add, every cell compares its deadline with the new one in
// parallel and the chain shifts behind the insertion point. A tick first
// advances the time, then pops due entries from the front cell one by one;
// no new input is taken until no more entry is due or sixteen were popped.
// Results leave through one output register. A rejected add shows its result in
// the cycle after the transfer; a tick's first expired entry waits for ST_POP.
// Reset empties the table and clears the elapsed time; no clearing pass runs.
// A stalled output holds its result; popping waits, and a new input transfer
// is held off while the output register is full and stalled.
module deadline_timer_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [31:0] in_entry_data,
  input  logic [15:0]        in_delay_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [31:0] out_expired_data,
  output logic               out_last
);
  import dtq_pkg::*;

  state_t state_r, state_nxt;
  logic [DEADLINE_W-1:0] elapsed_r, elapsed_nxt;
  logic [POP_CNT_W-1:0]  pop_cnt_r, pop_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  cell_ctl_t             ctl;
  entry_t                ins_entry;
  entry_t                cells   [CAPACITY];
  logic                  goes    [CAPACITY];
  logic [DEADLINE_W:0]   dl_sum;
  logic                  in_xfer;
  logic                  out_free;
  logic                  full;
  logic                  front_due;
  logic                  next_due;
  logic                  is_last;

  assign dl_sum = {1'b0, elapsed_r} + (DEADLINE_W + 1)'(in_delay_seconds);
  assign ins_entry.valid    = 1'b1;
  assign ins_entry.deadline = dl_sum[DEADLINE_W] ? TIME_MAX : dl_sum[DEADLINE_W-1:0];
  assign ins_entry.data     = DATA_W'(in_entry_data);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   prev_g;
      if (gi == 0) begin : g_first
        assign prev_e = '0;
        assign prev_g = 1'b0;
      end else begin : g_mid
        assign prev_e = cells[gi-1];
        assign prev_g = goes[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_body
        assign next_e = cells[gi+1];
      end
      dtq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ins_entry (ins_entry),
        .prev_entry(prev_e),
        .prev_goes (prev_g),
        .next_entry(next_e),
        .entry_q   (cells[gi]),
        .goes_here (goes[gi])
      );
    end
  endgenerate

  assign full      = cells[CAPACITY-1].valid;
  assign front_due = cells[0].valid && (cells[0].deadline <= elapsed_r);
  assign next_due  = cells[1].valid && (cells[1].deadline <= elapsed_r);
  assign is_last   = !next_due || (pop_cnt_r == POP_CNT_W'(MAX_RESULTS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_xfer   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    elapsed_nxt   = elapsed_r;
    pop_cnt_nxt   = pop_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_func == FUNC_ADD) begin
            if (full) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_REJECT;
              out_data_nxt  = DATA_W'(in_entry_data);
              out_last_nxt  = 1'b1;
            end else begin
              ctl.ins = 1'b1;
            end
          end else begin
            if (elapsed_r != TIME_MAX) begin
              elapsed_nxt = elapsed_r + 1'b1;
            end
            pop_cnt_nxt = '0;
            state_nxt   = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (!front_due) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ctl.pop       = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EXPIRED;
          out_data_nxt  = cells[0].data;
          out_last_nxt  = is_last;
          pop_cnt_nxt   = pop_cnt_r + 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      pop_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      pop_cnt_r   <= pop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_expired_data = signed'(out_data_r);
  assign out_last         = out_last_r;

endmodule

>>> rtl/dtq_checker.sv
// Port-level checker for the deadline timer queue and its bind statement.
module dtq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [31:0] out_expired_data,
  input logic        out_last
);
  import dtq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_expired_data))
    else $error("stalled result changed or dropped");

  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_REJECT) |-> out_last)
    else $error("rejected add not marked as final result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == KIND_REJECT) |=>
      !(out_valid && (out_kind == KIND_EXPIRED) && !out_last && $past(out_last)))
    else $error("expired burst started without a tick after a reject");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_expired_data(out_expired_data),
  .out_last        (out_last)
);
